// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define FDS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked in the cycle after the trigger outside reset
`define FDS_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/fds_pkg.sv -----
// shared types and constants for the directory entry scanner
// no dependencies
package fds_pkg;

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] LAST_POS = 5'd31;
    localparam logic [POS_W-1:0] NAME_BYTES = 5'd11;

    localparam logic [POS_W-1:0] POS_FIRST = 5'd0;
    localparam logic [POS_W-1:0] POS_ATTR = 5'd11;
    localparam logic [POS_W-1:0] POS_PART_SUM = 5'd13;
    localparam logic [POS_W-1:0] POS_CLUS_HI0 = 5'd20;
    localparam logic [POS_W-1:0] POS_CLUS_HI1 = 5'd21;
    localparam logic [POS_W-1:0] POS_CLUS_LO0 = 5'd26;
    localparam logic [POS_W-1:0] POS_CLUS_LO1 = 5'd27;

    localparam logic [7:0] FREE_MARK = 8'hE5;
    localparam logic [7:0] END_MARK = 8'h00;
    localparam logic [7:0] LONG_MASK = 8'h3F;
    localparam logic [7:0] LONG_ATTR = 8'h0F;
    localparam int LAST_FLAG_BIT = 6;
    localparam int VOLUME_BIT = 3;

    typedef enum logic [2:0] {
        KIND_FREE   = 3'd0,
        KIND_END    = 3'd1,
        KIND_LONG   = 3'd2,
        KIND_VOLUME = 3'd3,
        KIND_SHORT  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_LAST   = 3'd1,
        ST_BAD_ORD   = 3'd2,
        ST_BAD_PART  = 3'd3,
        ST_BAD_SHORT = 3'd4
    } status_t;

    // what the capture stage knows about the entry in flight
    typedef struct packed {
        logic        last;
        logic [7:0]  first_byte;
        logic [7:0]  attribute_byte;
        logic [7:0]  part_checksum;
        logic [31:0] cluster;
        logic [7:0]  name_checksum;
    } entry_t;

endpackage

// ----- hdl/fds_capture.sv -----
// byte position counter, field latches and running name checksum
// depends on fds_pkg
module fds_capture
    import fds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data,
    input  logic       clear,
    output entry_t     entry
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       attr_reg, attr_next;
    logic [7:0]       part_reg, part_next;
    logic [31:0]      cluster_reg, cluster_next;
    logic [7:0]       sum_reg, sum_next;
    logic [POS_W-1:0] pos;
    logic [7:0]       sum_base;

    assign pos = clear ? '0 : pos_reg;
    assign sum_base = (pos == POS_FIRST) ? 8'h00 : sum_reg;

    always_comb
    begin
        pos_next = pos_reg;
        first_next = first_reg;
        attr_next = attr_reg;
        part_next = part_reg;
        cluster_next = cluster_reg;
        sum_next = sum_reg;
        if (step)
        begin
            pos_next = pos + 1'b1;
            // rotate right by one, then add
            if (pos < NAME_BYTES)
            begin
                sum_next = {sum_base[0], sum_base[7:1]} + data;
            end
            case (pos)
                POS_FIRST:    first_next = data;
                POS_ATTR:     attr_next = data;
                POS_PART_SUM: part_next = data;
                POS_CLUS_HI0: cluster_next[23:16] = data;
                POS_CLUS_HI1: cluster_next[31:24] = data;
                POS_CLUS_LO0: cluster_next[7:0] = data;
                POS_CLUS_LO1: cluster_next[15:8] = data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            first_reg <= '0;
            attr_reg <= '0;
            part_reg <= '0;
            cluster_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            first_reg <= first_next;
            attr_reg <= attr_next;
            part_reg <= part_next;
            cluster_reg <= cluster_next;
            sum_reg <= sum_next;
        end
    end

    // fields used at the last byte are all latched before it arrives
    always_comb
    begin
        entry.last = (pos == LAST_POS);
        entry.first_byte = first_reg;
        entry.attribute_byte = attr_reg;
        entry.part_checksum = part_reg;
        entry.cluster = cluster_reg;
        entry.name_checksum = sum_reg;
    end

endmodule

// ----- hdl/fds_classifier.sv -----
// entry classification, long-name sequence tracking and result register
// depends on fds_pkg
module fds_classifier
    import fds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        clear,
    input  entry_t      entry,
    input  logic        take,
    output logic        res_valid,
    output kind_t       res_kind,
    output status_t     res_status,
    output logic [31:0] res_cluster,
    output logic [7:0]  res_attr,
    output logic        res_long,
    output logic [7:0]  res_sum
);

    logic        active_reg, active_next;
    logic [7:0]  ord_reg, ord_next;
    logic [7:0]  seq_sum_reg, seq_sum_next;
    logic        ended_reg, ended_next;
    logic        valid_reg, valid_next;
    kind_t       kind_reg, kind_next;
    status_t     status_reg, status_next;
    logic [31:0] cluster_reg, cluster_next;
    logic [7:0]  attr_reg;
    logic        long_reg, long_next;
    logic [7:0]  sum_reg;
    logic        emit;
    logic [7:0]  ord_dec;

    assign emit = step && entry.last && !ended_reg;
    assign ord_dec = ord_reg - 8'd1;

    always_comb
    begin
        active_next = active_reg;
        ord_next = ord_reg;
        seq_sum_next = seq_sum_reg;
        ended_next = ended_reg;
        kind_next = KIND_SHORT;
        status_next = ST_OK;
        cluster_next = '0;
        long_next = 1'b0;
        if (step && clear)
        begin
            active_next = 1'b0;
            ord_next = '0;
            seq_sum_next = '0;
            ended_next = 1'b0;
        end
        if (entry.first_byte == FREE_MARK)
        begin
            kind_next = KIND_FREE;
        end
        else if (entry.first_byte == END_MARK)
        begin
            kind_next = KIND_END;
        end
        else if ((entry.attribute_byte & LONG_MASK) == LONG_ATTR)
        begin
            kind_next = KIND_LONG;
            if (!active_reg)
            begin
                if (!entry.first_byte[LAST_FLAG_BIT])
                begin
                    status_next = ST_NO_LAST;
                end
            end
            else if (entry.first_byte != ord_dec)
            begin
                status_next = ST_BAD_ORD;
            end
            else if (entry.part_checksum != seq_sum_reg)
            begin
                status_next = ST_BAD_PART;
            end
        end
        else if (entry.attribute_byte[VOLUME_BIT])
        begin
            kind_next = KIND_VOLUME;
        end
        else
        begin
            cluster_next = entry.cluster;
            if (active_reg)
            begin
                if (entry.name_checksum == seq_sum_reg)
                begin
                    long_next = 1'b1;
                end
                else
                begin
                    status_next = ST_BAD_SHORT;
                end
            end
        end

        // sequence update, only when a result is produced
        if (emit)
        begin
            case (kind_next)
                KIND_END:
                begin
                    ended_next = 1'b1;
                    active_next = 1'b0;
                    ord_next = '0;
                    seq_sum_next = '0;
                end
                KIND_LONG:
                begin
                    if (status_next != ST_OK)
                    begin
                        active_next = 1'b0;
                        ord_next = '0;
                        seq_sum_next = '0;
                    end
                    else if (!active_reg)
                    begin
                        active_next = 1'b1;
                        ord_next = entry.first_byte & ~(8'h01 << LAST_FLAG_BIT);
                        seq_sum_next = entry.part_checksum;
                    end
                    else
                    begin
                        ord_next = ord_dec;
                    end
                end
                KIND_SHORT:
                begin
                    active_next = 1'b0;
                    ord_next = '0;
                    seq_sum_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ord_reg <= '0;
            seq_sum_reg <= '0;
            ended_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ord_reg <= ord_next;
            seq_sum_reg <= seq_sum_next;
            ended_reg <= ended_next;
            valid_reg <= valid_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            status_reg <= status_next;
            cluster_reg <= cluster_next;
            attr_reg <= entry.attribute_byte;
            long_reg <= long_next;
            sum_reg <= entry.name_checksum;
        end
    end

    assign res_valid = valid_reg;
    assign res_kind = kind_reg;
    assign res_status = status_reg;
    assign res_cluster = cluster_reg;
    assign res_attr = attr_reg;
    assign res_long = long_reg;
    assign res_sum = sum_reg;

endmodule

// ----- hdl/fat_dir_entry_scanner.sv -----
// Directory entry scanner: takes one directory byte per cycle while the
// input is not stalled and, at the last of every 32 bytes, gives one result
// word with the entry kind, the long-name sequence status, attributes, name
// checksum and first cluster. Input words go into an input register and the
// result into an output register, so a word is taken every cycle while the
// output is free or being taken; the last byte passes the input register, then
// the result register. After an end-of-list entry no results come until restart.
// depends on fds_pkg, fds_capture, fds_classifier
module fat_dir_entry_scanner
    import fds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  entry_byte,
    input  logic        restart,
    output logic        entry_valid,
    input  logic        entry_stall,
    output logic [2:0]  entry_kind,
    output logic [2:0]  status,
    output logic [31:0] first_cluster,
    output logic [7:0]  attributes,
    output logic        has_long_name,
    output logic [7:0]  name_checksum
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;
    logic       advance;
    logic       step;
    logic       load;
    logic       take;
    entry_t     entry;
    kind_t      kind;
    status_t    stat;

    // the result register is free or being taken this cycle
    assign advance = !entry_valid || !entry_stall;
    assign step = in_valid_reg && advance;
    assign byte_stall = in_valid_reg && !advance;
    assign load = byte_valid && !byte_stall;
    assign take = entry_valid && !entry_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= entry_byte;
            in_restart_reg <= restart;
        end
    end

    fds_capture u_capture (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .data  (in_byte_reg),
        .clear (in_restart_reg),
        .entry (entry)
    );

    fds_classifier u_classifier (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .clear       (in_restart_reg),
        .entry       (entry),
        .take        (take),
        .res_valid   (entry_valid),
        .res_kind    (kind),
        .res_status  (stat),
        .res_cluster (first_cluster),
        .res_attr    (attributes),
        .res_long    (has_long_name),
        .res_sum     (name_checksum)
    );

    assign entry_kind = kind;
    assign status = stat;

endmodule

// ----- hdl/fds_checker.sv -----
// port-level checks for the directory entry scanner, bound to the top level
// depends on fds_pkg and assert_macros.svh
`include "assert_macros.svh"

module fds_checker
    import fds_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_stall,
    input logic        entry_valid,
    input logic        entry_stall,
    input logic [2:0]  entry_kind,
    input logic [2:0]  status,
    input logic [31:0] first_cluster,
    input logic        has_long_name
);

    `FDS_ASSERT_NEXT(a_result_holds, clk, rst_n, entry_valid && entry_stall, entry_valid && $stable(entry_kind) && $stable(status) && $stable(first_cluster), "stalled result word changed")
    `FDS_ASSERT(a_stall_only_when_full, clk, rst_n, !byte_stall || (entry_valid && entry_stall), "input stalled while result register could move")
    `FDS_ASSERT(a_short_only_fields, clk, rst_n, !entry_valid || entry_kind == KIND_SHORT || (first_cluster == 32'd0 && !has_long_name), "cluster or long-name flag on a non-short entry")
    `FDS_ASSERT(a_plain_kinds_ok, clk, rst_n, !entry_valid || !(entry_kind == KIND_FREE || entry_kind == KIND_END || entry_kind == KIND_VOLUME) || status == ST_OK, "error status on free, end or volume entry")
    `FDS_ASSERT(a_long_name_ok, clk, rst_n, !(entry_valid && has_long_name) || status == ST_OK, "long-name flag with error status")

endmodule

bind fat_dir_entry_scanner fds_checker u_fds_checker (.*);
